// ===== rtl/core/modexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants
// Word width, register indexes and state encodings for the exponent core.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int WORD_BITS = 64;
	localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	localparam logic REG_MODULUS  = 1'b0;
	localparam logic REG_EXPONENT = 1'b1;

	localparam word_t MOD_RESET = word_t'(1);
	localparam word_t EXP_RESET = word_t'(65537);

	// multiplier control
	typedef enum logic [1:0] {
		MM_IDLE,
		MM_RUN,
		MM_DONE
	} mm_state_t;

	// top-level sequencer
	typedef enum logic [2:0] {
		SQ_IDLE,
		SQ_REDUCE,
		SQ_SCAN,
		SQ_SQUARE,
		SQ_MULT,
		SQ_OUT
	} sq_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/modexp_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod: bit-serial modular multiplier
// Computes a*b mod n by double-and-add, one multiplier bit per cycle.
// Operands must already be below n; n == 0 means modulo 2^WORD_BITS.
// ----------------------------------------------------------------------------
module modexp_mulmod import modexp_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  word_t a,
	input  word_t b,
	input  word_t n,
	output logic  done,
	output word_t r
);

	mm_state_t state_q, state_d;
	word_t     a_q, b_q, n_q, r_q;
	cnt_t      cnt_q;
	word_t     dbl, sum;

	// add_mod(x,y): x + y, minus n if it reaches n; n == 0 wraps.
	function automatic word_t add_mod(word_t x, word_t y, word_t m);
		logic [WORD_BITS:0] s;
		logic [WORD_BITS:0] d;
		s = {1'b0, x} + {1'b0, y};
		d = s - {1'b0, m};
		if (m == '0)
			return s[WORD_BITS-1:0];
		else if (s >= {1'b0, m})
			return d[WORD_BITS-1:0];
		else
			return s[WORD_BITS-1:0];
	endfunction

	assign dbl  = add_mod(r_q, r_q, n_q);
	assign sum  = add_mod(dbl, a_q, n_q);
	assign done = (state_q == MM_DONE);
	assign r    = r_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			MM_IDLE: if (start) state_d = MM_RUN;
			MM_RUN:  if (cnt_q == cnt_t'(1)) state_d = MM_DONE;
			MM_DONE: state_d = MM_IDLE;
			default: state_d = MM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == MM_IDLE && start)
				cnt_q <= cnt_t'(WORD_BITS);
			else if (state_q == MM_RUN)
				cnt_q <= cnt_q - cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == MM_IDLE && start) begin
			a_q <= a;
			b_q <= b;
			n_q <= n;
			r_q <= '0;
		end else if (state_q == MM_RUN) begin
			r_q <= b_q[WORD_BITS-1] ? sum : dbl;
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: left-to-right square-and-multiply, base^e mod n
// Steps: base reduction by restoring division, then one scan step per
// exponent bit; from the top set bit down, each bit adds one squaring and,
// for a one bit, a multiply, each on the serial multiplier. One item at a time.
// Reset: modulus 1, exponent 65537, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	// configuration
	input  wire   cfg_valid,
	output logic  cfg_ready,
	input  wire   cfg_index,
	input  word_t cfg_data,
	// input items
	input  wire   in_valid,
	output logic  in_ready,
	input  word_t base,
	// results
	output logic  out_valid,
	input  wire   out_ready,
	output word_t power
);

	sq_state_t state_q, state_d;
	word_t     modulus_q, exponent_q;
	word_t     acc_q, hbase_q, exp_q, rem_q, num_q;
	cnt_t      bits_q;       // exponent bits left, including current
	cnt_t      rcnt_q;
	logic      cur_bit_q;
	logic      seen_q;       // top set bit already passed
	logic      mm_start, mm_done;
	word_t     mm_a, mm_b, mm_r;
	logic [WORD_BITS:0] rem_sh, rem_sub;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == SQ_IDLE);
	assign out_valid = (state_q == SQ_OUT);
	assign power     = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= MOD_RESET;
			exponent_q <= EXP_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q  <= cfg_data;
				REG_EXPONENT: exponent_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Restoring division for base mod n, one quotient bit per cycle.
	assign rem_sh  = {rem_q, num_q[WORD_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, modulus_q};

	// Multiplier operands: square acc or multiply acc by the held base.
	assign mm_a = acc_q;
	assign mm_b = (state_q == SQ_MULT) ? hbase_q : acc_q;

	modexp_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.n      (modulus_q),
		.done   (mm_done),
		.r      (mm_r)
	);

	logic busy_q;

	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		unique case (state_q)
			SQ_IDLE:
				if (in_valid) state_d = SQ_REDUCE;
			SQ_REDUCE:
				if (rcnt_q == '0) state_d = SQ_SCAN;
			SQ_SCAN:
				if (bits_q == '0) state_d = SQ_OUT;
				else if (exp_q[WORD_BITS-1] || seen_q) state_d = SQ_SQUARE;
			SQ_SQUARE: begin
				mm_start = !busy_q;
				if (mm_done) state_d = cur_bit_q ? SQ_MULT : SQ_SCAN;
			end
			SQ_MULT: begin
				mm_start = !busy_q;
				if (mm_done) state_d = SQ_SCAN;
			end
			SQ_OUT:
				if (out_ready) state_d = SQ_IDLE;
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			busy_q  <= 1'b0;
			bits_q  <= '0;
			rcnt_q  <= '0;
			seen_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mm_done)
				busy_q <= 1'b0;
			else if (mm_start)
				busy_q <= 1'b1;
			if (state_q == SQ_IDLE && in_valid) begin
				bits_q <= cnt_t'(WORD_BITS);
				rcnt_q <= cnt_t'(WORD_BITS);
			end else if (state_q == SQ_REDUCE && rcnt_q != '0) begin
				rcnt_q <= rcnt_q - cnt_t'(1);
			end else if (state_q == SQ_SCAN && bits_q != '0) begin
				bits_q <= bits_q - cnt_t'(1);
			end
			if (state_q == SQ_IDLE && in_valid)
				seen_q <= 1'b0;
			else if (state_q == SQ_SCAN && bits_q != '0 && exp_q[WORD_BITS-1])
				seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SQ_IDLE: if (in_valid) begin
				num_q <= base;
				rem_q <= '0;
				exp_q <= exponent_q;
				acc_q <= word_t'(1);
			end
			SQ_REDUCE: begin
				if (rcnt_q != '0) begin
					num_q <= {num_q[WORD_BITS-2:0], 1'b0};
					if (modulus_q != '0 && !rem_sub[WORD_BITS])
						rem_q <= rem_sub[WORD_BITS-1:0];
					else
						rem_q <= rem_sh[WORD_BITS-1:0];
				end else begin
					// walk done: rem holds base mod n, or base itself for a zero modulus
					hbase_q <= rem_q;
				end
			end
			SQ_SCAN: if (bits_q != '0) begin
				cur_bit_q <= exp_q[WORD_BITS-1];
				exp_q     <= {exp_q[WORD_BITS-2:0], 1'b0};
			end
			SQ_SQUARE, SQ_MULT: if (mm_done) acc_q <= mm_r;
			default: ;
		endcase
	end

	// Leading zeros: acc stays 1 through scan cycles until the first one
	// bit, so squaring only starts at the top set bit.

endmodule
`default_nettype wire

// ===== dv/modular_exponentiation_tb.sv =====
// ----------------------------------------------------------------------------
// modular_exponentiation_tb: self-checking bench for the modexp core
// Drives bases through valid/ready, predicts base^e mod n with a bit-serial
// square-and-multiply, and checks every power in order. The run covers
// directed corner rows and then random bases across several register settings.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
	import modexp_pkg::*;

	localparam int LIMIT = 4000000;

	logic  clk;
	logic  arst_n;
	logic  cfg_valid;
	logic  cfg_ready;
	logic  cfg_index;
	word_t cfg_data;
	logic  in_valid;
	logic  in_ready;
	word_t base;
	logic  out_valid;
	logic  out_ready;
	word_t power;

	modular_exponentiation dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.base     (base),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.power    (power)
	);

	// predictor copy of the two registers
	word_t mod_reg;
	word_t exp_reg;

	word_t pending_powers[$];
	int    mismatches;
	int    powers_seen;
	int    bases_sent;
	int    settings_used;
	int    cycles;
	bit    draining;

	// directed rows: base, registers to load, and typed expected where obvious
	typedef struct {
		bit    load;
		word_t n;
		word_t e;
		word_t b;
		bit    known;
		word_t want;
	} row_t;

	row_t rows[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_row(bit load, word_t n, word_t e, word_t b, bit known,
		word_t want);
		row_t r;
		r.load  = load;
		r.n     = n;
		r.e     = e;
		r.b     = b;
		r.known = known;
		r.want  = want;
		rows.insert(rows.size(), r);
	endfunction

	// (a + b) mod n with a, b below n; n of zero wraps at 2^64
	function automatic word_t add_mod(word_t a, word_t b, word_t n);
		logic [WORD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (n == '0)
			return s[WORD_BITS-1:0];
		if (s >= {1'b0, n})
			s = s - {1'b0, n};
		return s[WORD_BITS-1:0];
	endfunction

	function automatic word_t mul_mod(word_t a, word_t b, word_t n);
		word_t r;
		r = '0;
		if (n != '0) begin
			a = a % n;
			b = b % n;
		end
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			r = add_mod(r, r, n);
			if (b[i])
				r = add_mod(r, a, n);
		end
		return r;
	endfunction

	function automatic word_t predict_power(word_t b);
		word_t acc;
		word_t hb;
		int    top;
		acc = word_t'(1);
		top = -1;
		hb  = (mod_reg != '0) ? b % mod_reg : b;
		for (int i = WORD_BITS - 1; i >= 0; i--)
			if (exp_reg[i] && top < 0)
				top = i;
		for (int i = top; i >= 0; i--) begin
			acc = mul_mod(acc, acc, mod_reg);
			if (exp_reg[i])
				acc = mul_mod(acc, hb, mod_reg);
		end
		return acc;
	endfunction

	function automatic word_t rand_word();
		return {$urandom(), $urandom()};
	endfunction

	task automatic idle_cycles(int k);
		repeat (k) @(posedge clk);
	endtask

	// cfg_valid is dropped by the caller once all writes are done
	task automatic write_reg(logic idx, word_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_MODULUS)
			mod_reg = val;
		else
			exp_reg = val;
	endtask

	// wait for all powers plus some margin, then load both registers
	task automatic set_regs(word_t n, word_t e);
		in_valid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		idle_cycles(20);
		write_reg(REG_MODULUS, n);
		write_reg(REG_EXPONENT, e);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// in_valid stays high after a transfer when the next base follows at once
	task automatic send_base(word_t b, bit known, word_t want);
		word_t p;
		int    gap;
		gap = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			idle_cycles(gap);
		end
		p = predict_power(b);
		if (known && p != want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("predictor disagrees with table: base %h want %h got %h",
					b, want, p);
		end
		pending_powers.insert(pending_powers.size(), p);
		in_valid <= 1'b1;
		base     <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bases_sent++;
	endtask

	// result side: random stalls, compare against the oldest expectation
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
			if (stall > 0) begin
				out_ready <= 1'b0;
				idle_cycles(stall);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			// transfer happened at this edge
			powers_seen++;
			if (pending_powers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected power %h", power);
			end else begin
				word_t w;
				w = pending_powers.pop_front();
				if (w !== power) begin
					mismatches++;
					if (mismatches <= 10)
						$display("power mismatch: expected %h actual %h", w, power);
				end
			end
		end
	end

	// watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("modular_exponentiation_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		word_t big;
		big = '1;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		in_valid = 1'b0;
		base = '0;
		mismatches = 0;
		powers_seen = 0;
		bases_sent = 0;
		settings_used = 0;
		mod_reg = MOD_RESET;
		exp_reg = EXP_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: modulus one with a nonzero exponent gives zero
		add_row(0, '0, '0, word_t'(5), 1, '0);
		add_row(0, '0, '0, big, 1, '0);
		// zero exponent gives one even for modulus one
		add_row(1, word_t'(1), '0, word_t'(7), 1, word_t'(1));
		add_row(1, big, '0, big, 1, word_t'(1));
		// small known values
		add_row(1, word_t'(13), word_t'(2), word_t'(5), 1, word_t'(12));
		add_row(0, '0, '0, word_t'(13), 1, '0);
		add_row(0, '0, '0, word_t'(18), 1, word_t'(12));
		add_row(1, big, word_t'(1), big, 1, '0);
		add_row(0, '0, '0, big - 1, 1, big - 1);
		add_row(0, '0, '0, '0, 1, '0);
		// zero modulus wraps at 2^64
		add_row(1, '0, word_t'(2), big, 1, word_t'(1));
		add_row(0, '0, '0, word_t'(64'h1_0000_0000), 1, '0);
		// full-width and 65537 exponents, large moduli
		add_row(1, big, big, word_t'(3), 0, '0);
		add_row(0, '0, '0, big, 0, '0);
		add_row(0, '0, '0, word_t'(64'h8000_0000_0000_0000), 0, '0);
		add_row(1, word_t'(64'h8000_0000_0000_0001), word_t'(65537),
			word_t'(12345), 0, '0);
		add_row(0, '0, '0, word_t'(64'h5555_5555_5555_5555), 0, '0);
		add_row(0, '0, '0, word_t'(64'haaaa_aaaa_aaaa_aaaa), 0, '0);

		foreach (rows[i]) begin
			if (rows[i].load)
				set_regs(rows[i].n, rows[i].e);
			send_base(rows[i].b, rows[i].known, rows[i].want);
		end

		// random phases across settings; exponents small, shifted or full width
		for (int ph = 0; ph < 8; ph++) begin
			word_t n;
			word_t e;
			case (ph % 4)
				0: n = rand_word() | 64'h8000_0000_0000_0001;
				1: n = word_t'($urandom_range(1, 1000));
				2: n = rand_word();
				default: n = (ph == 3) ? '0 : big;
			endcase
			case (ph % 3)
				0: e = word_t'($urandom_range(0, 70000));
				1: e = rand_word() >> $urandom_range(0, 63);
				default: e = rand_word();
			endcase
			set_regs(n, e);
			for (int k = 0; k < 10; k++) begin
				word_t b;
				b = ($urandom_range(0, 5) == 0) ? ((k % 2) ? big : '0) : rand_word();
				send_base(b, 0, '0);
			end
			// sender holds off until every power is back
			if (ph == 4) begin
				in_valid <= 1'b0;
				while (pending_powers.size() != 0)
					@(posedge clk);
			end
		end

		in_valid <= 1'b0;
		while (pending_powers.size() != 0)
			@(posedge clk);
		idle_cycles(200);

		$display("ran %0d bases over %0d register settings, %0d powers checked",
			bases_sent, settings_used, powers_seen);
		$display("corners: modulus one and zero, zero and full exponents, extreme bases");
		if (mismatches == 0 && pending_powers.size() == 0)
			$display("modular_exponentiation_tb: clean");
		else begin
			$display("%0d mismatches", mismatches);
			$display("modular_exponentiation_tb: errors");
		end
		$finish;
	end

endmodule
